/* rtl/hsa_pkg.sv */
// shared types and constants of the hexagonal snowflake automaton
package hsa_pkg;

    localparam int VAPOR_W = 24;
    localparam int COEF_W  = 17;
    localparam int CNT_W   = 13;
    localparam int GEN_W   = 16;
    localparam int NSUM_W  = 27;
    localparam int RADD_W  = 25;

    localparam logic [VAPOR_W-1:0] VAPOR_MAX = 24'hFFFFFF;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 13'd8191;

    // reciprocal of three, scaled by 2^28
    localparam logic [27:0] RECIP3 = 28'd89478485;

    // reset values of the registers
    localparam logic [COEF_W-1:0]  RST_ALPHA = 17'd65536;
    localparam logic [COEF_W-1:0]  RST_BETA  = 17'd26214;
    localparam logic [COEF_W-1:0]  RST_GAMMA = 17'd7;
    localparam logic [VAPOR_W-1:0] RST_THR   = 24'd65536;

    // request codes
    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA  = 2'd1;
    localparam logic [1:0] CFG_GAMMA = 2'd2;
    localparam logic [1:0] CFG_THR   = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
    } t_req;

    typedef struct packed {
        logic [23:0] vapor_value;
        logic        cell_is_ice;
        logic [12:0] ice_cell_count;
        logic [15:0] generation;
    } t_res;

    typedef struct packed {
        logic valid;
        logic last;
        logic ice;
    } t_upd_ctl;

endpackage

/* rtl/hsa_cell.sv */
// one lattice cell of the shift chain: holds vapor and receptive flag
module hsa_cell (
    input  logic                        i_clk,
    input  logic [hsa_pkg::VAPOR_W-1:0] i_vapor,
    input  logic                        i_recv,
    input  logic [hsa_pkg::VAPOR_W-1:0] i_thr,
    output logic [hsa_pkg::VAPOR_W-1:0] o_vapor,
    output logic                        o_recv,
    output logic                        o_ice,
    output logic [hsa_pkg::VAPOR_W-1:0] o_contrib
);
    import hsa_pkg::*;

    logic [VAPOR_W-1:0] r_vapor;
    logic               r_recv;

    // take the word from the upstream neighbor every cycle
    always_ff @(posedge i_clk) begin
        r_vapor <= i_vapor;
        r_recv  <= i_recv;
    end

    // ice test and diffusion share
    assign o_vapor   = r_vapor;
    assign o_recv    = r_recv;
    assign o_ice     = (r_vapor >= i_thr);
    assign o_contrib = r_recv ? '0 : r_vapor;

endmodule

/* rtl/hsa_update.sv */
// pipelined new-vapor arithmetic: weights, scale by 1/786432, add, saturate
module hsa_update #(
    parameter int IDX_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_last,
    input  logic [IDX_W-1:0]            i_idx,
    input  logic [hsa_pkg::VAPOR_W-1:0] i_own,
    input  logic [hsa_pkg::NSUM_W-1:0]  i_nsum,
    input  logic [hsa_pkg::RADD_W-1:0]  i_radd,
    input  logic [hsa_pkg::COEF_W-1:0]  i_alpha,
    input  logic [hsa_pkg::VAPOR_W-1:0] i_thr,
    output hsa_pkg::t_upd_ctl           o_ctl,
    output logic [IDX_W-1:0]            o_idx,
    output logic [hsa_pkg::VAPOR_W-1:0] o_vapor
);
    import hsa_pkg::*;

    logic [17:0] w_diff;
    logic [19:0] w_ownw;
    logic [43:0] w_p1;
    logic [43:0] w_p2;
    logic [44:0] w_num;
    logic [54:0] w_prod;
    logic [26:0] w_three_t;
    logic [26:0] w_rem;
    logic [26:0] w_quot;
    logic [26:0] w_sum;
    logic [VAPOR_W-1:0] w_sat;

    logic               r1_valid, r1_last;
    logic [IDX_W-1:0]   r1_idx;
    logic [43:0]        r1_p1, r1_p2;
    logic [RADD_W-1:0]  r1_radd;
    logic               r2_valid, r2_last;
    logic [IDX_W-1:0]   r2_idx;
    logic [26:0]        r2_q;
    logic [RADD_W-1:0]  r2_radd;
    logic               r3_valid, r3_last;
    logic [IDX_W-1:0]   r3_idx;
    logic [26:0]        r3_q;
    logic [25:0]        r3_t;
    logic [RADD_W-1:0]  r3_radd;
    logic               r4_valid, r4_last, r4_ice;
    logic [IDX_W-1:0]   r4_idx;
    logic [VAPOR_W-1:0] r4_vapor;

    // own weight (2 - alpha) * 6 in Q4.16
    assign w_diff = 18'd131072 - {1'b0, i_alpha};
    assign w_ownw = {w_diff, 2'b00} + {1'b0, w_diff, 1'b0};

    // products
    assign w_p1 = {20'd0, i_own} * {24'd0, w_ownw};
    assign w_p2 = {17'd0, i_nsum} * {27'd0, i_alpha};

    // sum and drop the power-of-two part of 786432
    assign w_num = {1'b0, r1_p1} + {1'b0, r1_p2};

    // divide by three through the reciprocal
    assign w_prod = {28'd0, r2_q} * {27'd0, RECIP3};

    // one correction step, then receptive part and saturation
    assign w_three_t = {r3_t, 1'b0} + {1'b0, r3_t};
    assign w_rem     = r3_q - w_three_t;
    assign w_quot    = {1'b0, r3_t} + ((w_rem >= 27'd3) ? 27'd1 : 27'd0);
    assign w_sum     = w_quot + {2'b00, r3_radd};
    assign w_sat     = (w_sum > {3'b000, VAPOR_MAX}) ? VAPOR_MAX : w_sum[VAPOR_W-1:0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r1_last  <= i_last;
        r1_idx   <= i_idx;
        r1_p1    <= w_p1;
        r1_p2    <= w_p2;
        r1_radd  <= i_radd;
        r2_last  <= r1_last;
        r2_idx   <= r1_idx;
        r2_q     <= w_num[44:18];
        r2_radd  <= r1_radd;
        r3_last  <= r2_last;
        r3_idx   <= r2_idx;
        r3_q     <= r2_q;
        r3_t     <= w_prod[53:28];
        r3_radd  <= r2_radd;
        r4_last  <= r3_last;
        r4_idx   <= r3_idx;
        r4_vapor <= w_sat;
        r4_ice   <= (w_sat >= i_thr);
    end

    assign o_ctl.valid = r4_valid;
    assign o_ctl.last  = r4_last;
    assign o_ctl.ice   = r4_ice;
    assign o_idx       = r4_idx;
    assign o_vapor     = r4_vapor;

endmodule

/* rtl/hex_snowflake_automaton_step.sv */
// top level: lattice memory, two cell chains, update pipeline and control
//
// A read passes the memory read register and then the result register before it reports; an unknown
// request reports straight from the result register. A restart refills the lattice one cell per cycle
// through the memory write port and then reports; a step streams every cell through the single read port
// in raster order and two chains of 2*LATTICE_WIDTH+3 cells, then through the update pipeline, and
// reports once the update of the last cell arrives. After reset the lattice is filled by the same pass,
// with busy high and no result. Each result is shown on o_result for one cycle with o_strobe high and
// must be taken then; the receiver cannot stall the block.
module hex_snowflake_automaton_step #(
    parameter int LATTICE_WIDTH  = 64,
    parameter int LATTICE_HEIGHT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  hsa_pkg::t_req               i_req,
    output logic                        o_strobe,
    output hsa_pkg::t_res               o_result,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [hsa_pkg::VAPOR_W-1:0] i_cfg_data
);
    import hsa_pkg::*;

    localparam int W      = LATTICE_WIDTH;
    localparam int H      = LATTICE_HEIGHT;
    localparam int N      = W * H;
    localparam int IDX_W  = $clog2(N);
    localparam int XW     = $clog2(W);
    localparam int YW     = $clog2(H);
    localparam int CH     = 2 * W + 3;
    localparam int TW     = $clog2(N + 2 * W + 6);
    localparam int CENTRE = (H / 2) * W + W / 2;
    localparam int DEPTH  = 2 ** (IDX_W + 1);
    localparam int CNT_FULL = (N > 8191) ? 8191 : N;

    // chain tap positions relative to the newest cell
    localparam int K_C  = W + 1;
    localparam int K_L  = W + 2;
    localparam int K_R  = W;
    localparam int K_U  = 2 * W + 1;
    localparam int K_D  = 1;
    localparam int K_UL = 2 * W + 2;
    localparam int K_UR = 2 * W;
    localparam int K_DL = 2;
    localparam int K_DR = 0;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam logic [CNT_W-1:0] RST_CNT =
        (RST_BETA >= RST_THR) ? CNT_W'(CNT_FULL) : CNT_W'(1);

    // neighbor presence: L R U D UL UR DL DR
    function automatic logic [7:0] nb_mask(input logic [XW-1:0] x, input logic [YW-1:0] y);
        logic ml, mr, mu, md, ev;
        ml = (x != '0);
        mr = (x != XW'(W - 1));
        mu = (y != '0);
        md = (y != YW'(H - 1));
        ev = !y[0];
        return {!ev & md & mr, ev & md & ml, !ev & mu & mr, ev & mu & ml, md, mu, mr, ml};
    endfunction

    logic [COEF_W-1:0]  r_alpha, r_beta, r_gamma;
    logic [VAPOR_W-1:0] r_thr;
    logic [1:0]         r_state;
    logic               r_bank;
    logic [GEN_W-1:0]   r_gen;
    logic [CNT_W-1:0]   r_ice_total;
    logic [CNT_W-1:0]   r_acc;
    logic [IDX_W-1:0]   r_fill_cnt;
    logic [COEF_W-1:0]  r_fill_beta;
    logic [VAPOR_W-1:0] r_fill_thr;
    logic               r_fill_report;
    logic [TW-1:0]      r_t;
    logic [XW-1:0]      r_xa, r_xb;
    logic [YW-1:0]      r_ya, r_yb;
    logic [IDX_W-1:0]   r_ib;
    logic               r_rd_inrange;
    logic [VAPOR_W-1:0] r_rdata;
    logic               r_out_valid;
    t_res               r_out;

    logic               r_b_valid, r_b_last;
    logic [IDX_W-1:0]   r_b_idx;
    logic [VAPOR_W-1:0] r_b_own;
    logic [NSUM_W-1:0]  r_b_nsum;
    logic [RADD_W-1:0]  r_b_radd;

    logic [VAPOR_W-1:0] mem [DEPTH];

    logic               w_acc;
    logic [15:0]        w_lin;
    logic               w_inrange;
    logic               w_we;
    logic [IDX_W:0]     w_waddr;
    logic [IDX_W:0]     w_raddr;
    logic [VAPOR_W-1:0] w_wdata;
    logic               a_valid, b_valid;
    logic [7:0]         ma, mb;
    logic               a_recv;
    logic [NSUM_W-1:0]  b_nsum;
    logic [RADD_W-1:0]  b_radd;
    logic [CNT_W-1:0]   n_cnt;
    t_upd_ctl           u_ctl;
    logic [IDX_W-1:0]   u_idx;
    logic [VAPOR_W-1:0] u_vap;

    logic [VAPOR_W-1:0] c1_vap [CH];
    logic               c1_ice [CH];
    logic [VAPOR_W-1:0] c2_vap [CH];
    logic               c2_recv [CH];
    logic [VAPOR_W-1:0] c2_con [CH];

    assign busy     = (r_state != ST_IDLE);
    assign w_acc    = start && !busy;
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // read address of a single-cell request
    assign w_lin     = 16'(i_req.cell_y) * 16'(W) + 16'(i_req.cell_x);
    assign w_inrange = (9'(i_req.cell_x) < 9'(W)) && (9'(i_req.cell_y) < 9'(H));

    // stream windows: valid ranges of the two chain centers
    assign a_valid = (r_state == ST_STEP) && (r_t >= TW'(W + 3)) && (r_t < TW'(N + W + 3));
    assign b_valid = (r_state == ST_STEP) && (r_t >= TW'(2 * W + 5))
                     && (r_t < TW'(N + 2 * W + 5));

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_bank, r_fill_cnt};
        w_wdata = (r_fill_cnt == IDX_W'(CENTRE)) ? r_fill_thr : VAPOR_W'(r_fill_beta);
        if (r_state == ST_FILL) begin
            w_we = 1'b1;
        end else if ((r_state == ST_STEP) && u_ctl.valid) begin
            w_we    = 1'b1;
            w_waddr = {!r_bank, u_idx};
            w_wdata = u_vap;
        end
        w_raddr = {r_bank, (r_state == ST_STEP) ? r_t[IDX_W-1:0] : w_lin[IDX_W-1:0]};
    end

    // lattice store, two banks of current and next vapor
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // first chain: vapor words straight from memory
    for (genvar k = 0; k < CH; k++) begin : g_c1
        if (k == 0) begin : g_head
            hsa_cell u_cell (
                .i_clk(i_clk), .i_vapor(r_rdata), .i_recv(1'b0), .i_thr(r_thr),
                .o_vapor(c1_vap[k]), .o_recv(), .o_ice(c1_ice[k]), .o_contrib()
            );
        end else begin : g_body
            hsa_cell u_cell (
                .i_clk(i_clk), .i_vapor(c1_vap[k-1]), .i_recv(1'b0), .i_thr(r_thr),
                .o_vapor(c1_vap[k]), .o_recv(), .o_ice(c1_ice[k]), .o_contrib()
            );
        end
    end

    // receptive test at the first chain center
    assign ma     = nb_mask(r_xa, r_ya);
    assign a_recv = c1_ice[K_C] | (ma[0] & c1_ice[K_L]) | (ma[1] & c1_ice[K_R])
                  | (ma[2] & c1_ice[K_U]) | (ma[3] & c1_ice[K_D])
                  | (ma[4] & c1_ice[K_UL]) | (ma[5] & c1_ice[K_UR])
                  | (ma[6] & c1_ice[K_DL]) | (ma[7] & c1_ice[K_DR]);

    // second chain: vapor plus receptive flag
    for (genvar k = 0; k < CH; k++) begin : g_c2
        if (k == 0) begin : g_head
            hsa_cell u_cell (
                .i_clk(i_clk), .i_vapor(c1_vap[K_C]), .i_recv(a_recv), .i_thr(r_thr),
                .o_vapor(c2_vap[k]), .o_recv(c2_recv[k]), .o_ice(), .o_contrib(c2_con[k])
            );
        end else begin : g_body
            hsa_cell u_cell (
                .i_clk(i_clk), .i_vapor(c2_vap[k-1]), .i_recv(c2_recv[k-1]), .i_thr(r_thr),
                .o_vapor(c2_vap[k]), .o_recv(c2_recv[k]), .o_ice(), .o_contrib(c2_con[k])
            );
        end
    end

    // neighbor sum and receptive part at the second chain center
    assign mb     = nb_mask(r_xb, r_yb);
    assign b_nsum = (mb[0] ? NSUM_W'(c2_con[K_L])  : '0) + (mb[1] ? NSUM_W'(c2_con[K_R])  : '0)
                  + (mb[2] ? NSUM_W'(c2_con[K_U])  : '0) + (mb[3] ? NSUM_W'(c2_con[K_D])  : '0)
                  + (mb[4] ? NSUM_W'(c2_con[K_UL]) : '0) + (mb[5] ? NSUM_W'(c2_con[K_UR]) : '0)
                  + (mb[6] ? NSUM_W'(c2_con[K_DL]) : '0) + (mb[7] ? NSUM_W'(c2_con[K_DR]) : '0);
    assign b_radd = c2_recv[K_C] ? (RADD_W'(c2_vap[K_C]) + RADD_W'(r_gamma)) : '0;

    // registers in front of the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_last <= (r_ib == IDX_W'(N - 1));
        r_b_idx  <= r_ib;
        r_b_own  <= c2_con[K_C];
        r_b_nsum <= b_nsum;
        r_b_radd <= b_radd;
    end

    hsa_update #(.IDX_W(IDX_W)) u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .i_last  (r_b_last),
        .i_idx   (r_b_idx),
        .i_own   (r_b_own),
        .i_nsum  (r_b_nsum),
        .i_radd  (r_b_radd),
        .i_alpha (r_alpha),
        .i_thr   (r_thr),
        .o_ctl   (u_ctl),
        .o_idx   (u_idx),
        .o_vapor (u_vap)
    );

    // running ice count, saturating
    assign n_cnt = ((r_acc == CNT_MAX) || !u_ctl.ice) ? r_acc : r_acc + 1'b1;

    // control and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= RST_ALPHA;
            r_beta        <= RST_BETA;
            r_gamma       <= RST_GAMMA;
            r_thr         <= RST_THR;
            r_state       <= ST_FILL;
            r_bank        <= 1'b0;
            r_gen         <= '0;
            r_ice_total   <= RST_CNT;
            r_acc         <= '0;
            r_fill_cnt    <= '0;
            r_fill_beta   <= RST_BETA;
            r_fill_thr    <= RST_THR;
            r_fill_report <= 1'b0;
            r_t           <= '0;
            r_xa          <= '0;
            r_ya          <= '0;
            r_xb          <= '0;
            r_yb          <= '0;
            r_ib          <= '0;
            r_rd_inrange  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            // configuration word
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALPHA: r_alpha <= i_cfg_data[COEF_W-1:0];
                    CFG_BETA:  r_beta  <= i_cfg_data[COEF_W-1:0];
                    CFG_GAMMA: r_gamma <= i_cfg_data[COEF_W-1:0];
                    CFG_THR:   r_thr   <= i_cfg_data;
                    default:   r_thr   <= r_thr;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (i_req.req_type)
                            REQ_RESTART: begin
                                r_state       <= ST_FILL;
                                r_fill_cnt    <= '0;
                                r_fill_beta   <= r_beta;
                                r_fill_thr    <= r_thr;
                                r_fill_report <= 1'b1;
                                r_gen         <= '0;
                                r_ice_total   <= ({7'd0, r_beta} >= r_thr) ?
                                                 CNT_W'(CNT_FULL) : CNT_W'(1);
                            end
                            REQ_STEP: begin
                                r_state <= ST_STEP;
                                r_t     <= '0;
                                r_xa    <= '0;
                                r_ya    <= '0;
                                r_xb    <= '0;
                                r_yb    <= '0;
                                r_ib    <= '0;
                                r_acc   <= '0;
                            end
                            REQ_READ: begin
                                r_state      <= ST_READ;
                                r_rd_inrange <= w_inrange;
                            end
                            default: begin
                                r_out_valid                <= 1'b1;
                                r_out.vapor_value          <= '0;
                                r_out.cell_is_ice          <= 1'b0;
                                r_out.ice_cell_count       <= r_ice_total;
                                r_out.generation           <= r_gen;
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    r_fill_cnt <= r_fill_cnt + 1'b1;
                    if (r_fill_cnt == IDX_W'(N - 1)) begin
                        r_state              <= ST_IDLE;
                        r_out_valid          <= r_fill_report;
                        r_out.vapor_value    <= '0;
                        r_out.cell_is_ice    <= 1'b0;
                        r_out.ice_cell_count <= r_ice_total;
                        r_out.generation     <= r_gen;
                    end
                end
                ST_STEP: begin
                    if (r_t != TW'(N + 2 * W + 5)) begin
                        r_t <= r_t + 1'b1;
                    end
                    if (a_valid) begin
                        if (r_xa == XW'(W - 1)) begin
                            r_xa <= '0;
                            r_ya <= r_ya + 1'b1;
                        end else begin
                            r_xa <= r_xa + 1'b1;
                        end
                    end
                    if (b_valid) begin
                        r_ib <= r_ib + 1'b1;
                        if (r_xb == XW'(W - 1)) begin
                            r_xb <= '0;
                            r_yb <= r_yb + 1'b1;
                        end else begin
                            r_xb <= r_xb + 1'b1;
                        end
                    end
                    if (u_ctl.valid) begin
                        r_acc <= n_cnt;
                    end
                    if (u_ctl.valid && u_ctl.last) begin
                        r_state              <= ST_IDLE;
                        r_bank               <= !r_bank;
                        r_gen                <= r_gen + 1'b1;
                        r_ice_total          <= n_cnt;
                        r_out_valid          <= 1'b1;
                        r_out.vapor_value    <= '0;
                        r_out.cell_is_ice    <= 1'b0;
                        r_out.ice_cell_count <= n_cnt;
                        r_out.generation     <= r_gen + 1'b1;
                    end
                end
                ST_READ: begin
                    r_state              <= ST_IDLE;
                    r_out_valid          <= 1'b1;
                    r_out.vapor_value    <= r_rd_inrange ? r_rdata : '0;
                    r_out.cell_is_ice    <= r_rd_inrange && (r_rdata >= r_thr);
                    r_out.ice_cell_count <= r_ice_total;
                    r_out.generation     <= r_gen;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a read request reports through the memory read register and the result register after accept
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.req_type == REQ_READ)) |=> ##1 o_strobe)
        else $error("read result missing");

    // update results only arrive during a step
    a_update_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_ctl.valid |-> (r_state == ST_STEP))
        else $error("update word outside a step");

    // a result word is shown only once the block is free
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while busy");
`endif

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the hexagonal snowflake automaton
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hsa_pkg::*;

    localparam int W = 64;
    localparam int H = 64;
    localparam int NCELL = W * H;
    localparam int LIMIT = 8000000;

    // request code outside the defined set
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_res o_result;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [VAPOR_W-1:0] i_cfg_data = '0;

    hex_snowflake_automaton_step #(.LATTICE_WIDTH(W), .LATTICE_HEIGHT(H)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [16:0] m_alpha = RST_ALPHA, m_beta = RST_BETA, m_gamma = RST_GAMMA;
    logic [23:0] m_thr = RST_THR;
    logic [23:0] lat [NCELL];
    logic [23:0] lat_nxt [NCELL];
    bit rcv [NCELL];
    int unsigned m_ice = 1;
    logic [15:0] m_gen = '0;

    t_req pending_words[$];
    t_res expected_words[$];
    int errors = 0;
    int cycles = 0;
    bit no_gaps = 0;
    int gap_left = 0;
    int n_steps = 0, n_reads = 0;

    function automatic void queue_word(t_req w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void queue_result(t_res w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void count_ice();
        int c;
        c = 0;
        for (int i = 0; i < NCELL; i++) if (lat[i] >= m_thr && c < 8191) c++;
        m_ice = c;
    endfunction

    function automatic void lattice_restart();
        for (int i = 0; i < NCELL; i++) lat[i] = 24'(m_beta);
        lat[(H/2)*W + W/2] = m_thr;
        m_gen = 0;
        count_ice();
    endfunction

    // one generation, receptive map first, then diffusion
    function automatic void lattice_advance();
        longint unsigned ownw, num, v, nsum, al;
        int x, y, yy, i;
        bit r;
        al = m_alpha;
        ownw = (131072 - al) * 6;
        for (y = 0; y < H; y++) for (x = 0; x < W; x++) begin
            i = y*W + x;
            r = lat[i] >= m_thr;
            if (x > 0 && lat[i-1] >= m_thr) r = 1;
            if (x < W-1 && lat[i+1] >= m_thr) r = 1;
            for (int dy = -1; dy <= 1; dy += 2) begin
                yy = y + dy;
                if (yy >= 0 && yy < H) begin
                    if (!y[0]) begin
                        if (x > 0 && lat[yy*W+x-1] >= m_thr) r = 1;
                    end else begin
                        if (x < W-1 && lat[yy*W+x+1] >= m_thr) r = 1;
                    end
                    if (lat[yy*W+x] >= m_thr) r = 1;
                end
            end
            rcv[i] = r;
        end
        for (y = 0; y < H; y++) for (x = 0; x < W; x++) begin
            i = y*W + x;
            nsum = 0;
            if (x > 0 && !rcv[i-1]) nsum += lat[i-1];
            if (x < W-1 && !rcv[i+1]) nsum += lat[i+1];
            for (int dy = -1; dy <= 1; dy += 2) begin
                yy = y + dy;
                if (yy >= 0 && yy < H) begin
                    if (!y[0]) begin
                        if (x > 0 && !rcv[yy*W+x-1]) nsum += lat[yy*W+x-1];
                    end else begin
                        if (x < W-1 && !rcv[yy*W+x+1]) nsum += lat[yy*W+x+1];
                    end
                    if (!rcv[yy*W+x]) nsum += lat[yy*W+x];
                end
            end
            num = (rcv[i] ? 64'd0 : 64'(lat[i])) * ownw + nsum * al;
            v = num / 786432;
            if (rcv[i]) v += 64'(lat[i]) + 64'(m_gamma);
            lat_nxt[i] = v > 64'hFFFFFF ? 24'hFFFFFF : v[23:0];
        end
        for (i = 0; i < NCELL; i++) lat[i] = lat_nxt[i];
        m_gen = m_gen + 1;
        count_ice();
    endfunction

    function automatic t_res predict_word(t_req rq);
        t_res rs;
        int i;
        rs = '0;
        case (rq.req_type)
            REQ_RESTART: lattice_restart();
            REQ_STEP: lattice_advance();
            REQ_READ: begin
                i = rq.cell_y * W + rq.cell_x;
                rs.vapor_value = lat[i];
                rs.cell_is_ice = lat[i] >= m_thr;
            end
            default: ;
        endcase
        rs.ice_cell_count = m_ice[12:0];
        rs.generation = m_gen;
        return rs;
    endfunction

    // driver: feeds queued words with random gaps, or back to back once no_gaps is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            // word accepted this edge
            queue_result(predict_word(i_req));
            void'(pending_words.pop_front());
            if (pending_words.size() > 0 && (no_gaps || $urandom_range(0, 3) != 0)) begin
                i_req <= pending_words[0];
            end else begin
                start <= 1'b0;
                if (!no_gaps) gap_left <= $urandom_range(1, 6);
            end
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
            start <= 1'b1;
            i_req <= pending_words[0];
        end
    end

    // monitor: compare each strobed word against the oldest prediction
    always @(posedge i_clk) begin
        t_res e;
        int bad;
        bad = 0;
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", o_result);
                bad++;
            end else begin
                e = expected_words.pop_front();
                if (o_result.vapor_value !== e.vapor_value) begin
                    $error("vapor_value exp %h got %h", e.vapor_value, o_result.vapor_value);
                    bad++;
                end
                if (o_result.cell_is_ice !== e.cell_is_ice) begin
                    $error("cell_is_ice exp %b got %b", e.cell_is_ice, o_result.cell_is_ice);
                    bad++;
                end
                if (o_result.ice_cell_count !== e.ice_cell_count) begin
                    $error("ice_cell_count exp %0d got %0d", e.ice_cell_count,
                           o_result.ice_cell_count);
                    bad++;
                end
                if (o_result.generation !== e.generation) begin
                    $error("generation exp %0d got %0d", e.generation, o_result.generation);
                    bad++;
                end
            end
        end
        errors <= errors + bad;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_req mk(logic [1:0] t, int x, int y);
        t_req r;
        r.req_type = t;
        r.cell_x = x[5:0];
        r.cell_y = y[5:0];
        return r;
    endfunction

    task automatic drain();
        while (pending_words.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (expected_words.size() != 0 || busy || start) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ALPHA: m_alpha = val[16:0];
            CFG_BETA: m_beta = val[16:0];
            CFG_GAMMA: m_gamma = val[16:0];
            default: m_thr = val;
        endcase
    endtask

    // run: restart, steps each followed by reads mostly around the centre, at times an unknown request
    task automatic push_growth(int nstep, int nread);
        queue_word(mk(REQ_RESTART, $urandom, $urandom));
        for (int k = 0; k < nstep; k++) begin
            queue_word(mk(REQ_STEP, $urandom, $urandom));
            n_steps++;
            for (int j = 0; j < nread; j++) begin
                if ($urandom_range(0, 2) == 0)
                    queue_word(mk(REQ_READ, $urandom, $urandom));
                else
                    queue_word(mk(REQ_READ, $urandom_range(28, 36),
                                  $urandom_range(28, 36)));
                n_reads++;
            end
        end
        if ($urandom_range(0, 4) == 0) queue_word(mk(REQ_UNKNOWN, $urandom, $urandom));
    endtask

    initial begin
        lattice_restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset fill pass, then idle
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed: reset lattice, corners, centre, unknown request, two steps
        queue_word(mk(REQ_READ, 32, 32));
        queue_word(mk(REQ_READ, 0, 0));
        queue_word(mk(REQ_READ, 63, 63));
        queue_word(mk(REQ_READ, 63, 0));
        queue_word(mk(REQ_READ, 0, 63));
        queue_word(mk(REQ_UNKNOWN, 63, 63));
        queue_word(mk(REQ_STEP, 0, 0));
        queue_word(mk(REQ_READ, 32, 32));
        queue_word(mk(REQ_READ, 33, 32));
        queue_word(mk(REQ_READ, 31, 31));
        queue_word(mk(REQ_READ, 0, 1));
        queue_word(mk(REQ_STEP, 0, 0));
        queue_word(mk(REQ_READ, 34, 32));
        queue_word(mk(REQ_READ, 63, 1));
        n_steps += 2;
        drain();

        // extremes: alpha max above one, big gamma, beta of 65536, maximum threshold
        cfg_write(CFG_ALPHA, 24'h1FFFF);
        cfg_write(CFG_BETA, 24'd65536);
        cfg_write(CFG_GAMMA, 24'd65536);
        cfg_write(CFG_THR, 24'hFFFFFF);
        push_growth(2, 2);
        drain();
        // threshold change takes effect at once
        cfg_write(CFG_THR, 24'd1);
        queue_word(mk(REQ_READ, 5, 5));
        queue_word(mk(REQ_STEP, 0, 0));
        queue_word(mk(REQ_READ, 5, 6));
        drain();
        cfg_write(CFG_THR, 24'd0);
        queue_word(mk(REQ_READ, 1, 2));
        queue_word(mk(REQ_STEP, 0, 0));
        queue_word(mk(REQ_READ, 62, 62));
        drain();
        cfg_write(CFG_ALPHA, 24'd0);
        cfg_write(CFG_BETA, 24'd0);
        cfg_write(CFG_GAMMA, 24'd0);
        cfg_write(CFG_THR, 24'd65536);
        push_growth(2, 2);
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_ALPHA, 24'($urandom_range(0, 131071)));
            cfg_write(CFG_BETA, 24'($urandom_range(0, 131071)));
            cfg_write(CFG_GAMMA, 24'($urandom_range(0, 131071)));
            cfg_write(CFG_THR, 24'($urandom_range(1, 24'hFFFFFF) | (ph == 5 ? 24'h800000 : 0)));
            push_growth($urandom_range(1, 3), $urandom_range(2, 5));
            for (int k = 0; k < 4; k++)
                queue_word(mk(2'($urandom_range(0, 3)), $urandom, $urandom));
            drain();
        end
        cfg_write(CFG_ALPHA, 24'(RST_ALPHA));
        cfg_write(CFG_BETA, 24'(RST_BETA));
        cfg_write(CFG_GAMMA, 24'(RST_GAMMA));
        cfg_write(CFG_THR, RST_THR);
        // last part: words back to back
        no_gaps = 1;
        push_growth(3, 4);
        drain();

        repeat (50) @(posedge i_clk);
        $display("covered %0d steps and %0d reads over several register settings",
                 n_steps, n_reads);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/hsa_pkg.sv
rtl/hsa_cell.sv
rtl/hsa_update.sv
rtl/hex_snowflake_automaton_step.sv
tb/sv/tb_top.sv
